// File: hdl/mexp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the modular exponentiation unit.
// No dependencies.
package mexp_pkg;

  localparam int DATA_W  = 64;
  localparam int WIDTH   = 64;
  localparam int CNT_W   = $clog2(WIDTH);
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] prod;
  } mm_rsp_t;

endpackage

// File: hdl/mexp_in_if.sv
`timescale 1ns / 1ps
// Input channel: message transfer with valid/ready.
// Depends on mexp_pkg.
interface mexp_in_if;
  logic                       valid;
  logic                       ready;
  logic [mexp_pkg::DATA_W-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

// File: hdl/mexp_out_if.sv
`timescale 1ns / 1ps
// Result channel: result and bad_modulus flag with valid/ready.
// Depends on mexp_pkg.
interface mexp_out_if;
  logic                       valid;
  logic                       ready;
  logic [mexp_pkg::DATA_W-1:0] result;
  logic                       bad_modulus;

  modport source (output valid, output result, output bad_modulus, input ready);
  modport sink   (input valid, input result, input bad_modulus, output ready);
endinterface

// File: hdl/mexp_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and data with valid/ready.
// Depends on mexp_pkg.
interface mexp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::CFG_IDX_W-1:0] reg_index;
  logic [mexp_pkg::DATA_W-1:0]    data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// File: hdl/mexp_mulmod.sv
`timescale 1ns / 1ps
// Bit-serial modular multiplier: a * b mod n by double-and-add, one modular
// add per cycle. Requires a < n and n >= 2; b may be any value.
// Depends on mexp_pkg.
module mexp_mulmod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mexp_pkg::mm_req_t            req,
  input  logic [mexp_pkg::WIDTH-1:0]   n,
  output mexp_pkg::mm_rsp_t            rsp
);

  typedef enum logic [2:0] {
    MM_IDLE = 3'b001,
    MM_DBL  = 3'b010,
    MM_ADD  = 3'b100
  } mm_state_t;

  mm_state_t                    st_r, st_nxt;
  logic [mexp_pkg::WIDTH-1:0]   acc_r, acc_nxt;
  logic [mexp_pkg::WIDTH-1:0]   a_r, a_nxt;
  logic [mexp_pkg::WIDTH-1:0]   b_r, b_nxt;
  logic [mexp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [mexp_pkg::WIDTH-1:0]   add_y;
  logic [mexp_pkg::WIDTH-1:0]   gap;
  logic [mexp_pkg::WIDTH-1:0]   add_res;

  // (acc + y) mod n with acc, y < n
  assign add_y   = (st_r == MM_ADD) ? a_r : acc_r;
  assign gap     = n - add_y;
  assign add_res = (acc_r >= gap) ? (acc_r - gap) : (acc_r + add_y);

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    case (st_r)
      MM_IDLE: begin
        if (req.start) begin
          acc_nxt = '0;
          a_nxt   = req.a;
          b_nxt   = req.b;
          cnt_nxt = mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
          st_nxt  = MM_DBL;
        end
      end
      MM_DBL: begin
        acc_nxt = add_res;
        if (b_r[mexp_pkg::WIDTH-1]) begin
          st_nxt = MM_ADD;
        end else if (cnt_r == '0) begin
          st_nxt   = MM_IDLE;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          b_nxt   = b_r << 1;
        end
      end
      MM_ADD: begin
        acc_nxt = add_res;
        if (cnt_r == '0) begin
          st_nxt   = MM_IDLE;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          b_nxt   = b_r << 1;
          st_nxt  = MM_DBL;
        end
      end
      default: begin
        st_nxt = MM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MM_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (st_r == MM_IDLE))
    else $error("mulmod started while busy");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != MM_IDLE) |-> (acc_r < n))
    else $error("mulmod partial sum not reduced");

  a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (st_r == MM_IDLE) && ($past(st_r) == MM_DBL || $past(st_r) == MM_ADD))
    else $error("mulmod done without a final step");

endmodule

// File: hdl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// Top level of the modular exponentiation unit: key registers, sequencer
// and output register. Depends on mexp_pkg, the channel interfaces and mexp_mulmod.
//
// Computes message^exponent mod modulus by right-to-left square-and-multiply
// on one shared bit-serial modular multiplier, one item at a time. An item
// takes one reduction pass of the message, then for each exponent bit up to
// the highest set one a multiply when the bit is set and a square except after
// the highest bit: at most 128 multiplications, and only the reduction for a
// zero exponent. When the modulus is below two, bad_modulus is set and the
// result is 0 with no multiplication. in_ready is high only while the sequencer
// is idle; the result sits in an output register until taken. The user must
// write exponent and modulus through the cfg channel (index 0 and 1) only while
// the unit is idle; the unit itself does not enforce this.
module modular_exponentiation_unit (
  input  logic       clk,
  input  logic       rst_n,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch,
  mexp_cfg_if.sink   cfg_ch
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_CHK  = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                     st_r, st_nxt;
  logic [mexp_pkg::WIDTH-1:0] exponent_r;
  logic [mexp_pkg::WIDTH-1:0] modulus_r;
  logic [mexp_pkg::WIDTH-1:0] e_r, e_nxt;
  logic [mexp_pkg::WIDTH-1:0] acc_r, acc_nxt;
  logic [mexp_pkg::WIDTH-1:0] base_r, base_nxt;
  logic                       bad_r, bad_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [mexp_pkg::DATA_W-1:0] out_result_r, out_result_nxt;
  logic                       out_bad_r, out_bad_nxt;
  logic                       in_xfer;
  mexp_pkg::mm_req_t          mm_req;
  mexp_pkg::mm_rsp_t          mm_rsp;

  assign in_ch.ready  = (st_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= '0;
      modulus_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        mexp_pkg::REG_EXPONENT: exponent_r <= cfg_ch.data[mexp_pkg::WIDTH-1:0];
        mexp_pkg::REG_MODULUS:  modulus_r  <= cfg_ch.data[mexp_pkg::WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt         = st_r;
    e_nxt          = e_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    bad_nxt        = bad_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_result_nxt = out_result_r;
    out_bad_nxt    = out_bad_r;
    mm_req.start   = 1'b0;
    mm_req.a       = base_r;
    mm_req.b       = base_r;
    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (modulus_r < mexp_pkg::WIDTH'(2)) begin
            acc_nxt = '0;
            bad_nxt = 1'b1;
            st_nxt  = S_DONE;
          end else begin
            // reduce the message: 1 * message mod n
            e_nxt        = exponent_r;
            acc_nxt      = mexp_pkg::WIDTH'(1);
            bad_nxt      = 1'b0;
            mm_req.start = 1'b1;
            mm_req.a     = mexp_pkg::WIDTH'(1);
            mm_req.b     = in_ch.message[mexp_pkg::WIDTH-1:0];
            st_nxt       = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_rsp.done) begin
          base_nxt = mm_rsp.prod;
          st_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        if (e_r == '0) begin
          st_nxt = S_DONE;
        end else if (e_r[0]) begin
          mm_req.start = 1'b1;
          mm_req.a     = acc_r;
          st_nxt       = S_MUL;
        end else begin
          mm_req.start = 1'b1;
          st_nxt       = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.prod;
          if (e_r[mexp_pkg::WIDTH-1:1] == '0) begin
            e_nxt  = '0;
            st_nxt = S_DONE;
          end else begin
            mm_req.start = 1'b1;
            st_nxt       = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_rsp.done) begin
          base_nxt = mm_rsp.prod;
          e_nxt    = e_r >> 1;
          st_nxt   = S_CHK;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = mexp_pkg::DATA_W'(acc_r);
          out_bad_nxt    = bad_r;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    e_r          <= e_nxt;
    acc_r        <= acc_nxt;
    base_r       <= base_nxt;
    bad_r        <= bad_nxt;
    out_result_r <= out_result_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .n     (modulus_r),
    .rsp   (mm_rsp)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result      = out_result_r;
  assign out_ch.bad_modulus = out_bad_r;

  a_bad_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && modulus_r < mexp_pkg::WIDTH'(2)) |=>
      (st_r == S_DONE) && bad_r && (acc_r == '0))
    else $error("bad modulus not flagged");

  a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CHK) |-> (acc_r < modulus_r) && (base_r < modulus_r) && !bad_r)
    else $error("operands not reduced");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && out_valid_r && !out_ch.ready) |=> (st_r == S_DONE))
    else $error("result dropped while output busy");

  a_mul_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (st_r == S_RED || st_r == S_MUL || st_r == S_SQR))
    else $error("multiplier result with no consumer");

endmodule

// File: bench/modular_exponentiation_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for modular_exponentiation_unit: directed keys, then random key phases.
// Depends on mexp_pkg, the mexp_in_if / mexp_out_if / mexp_cfg_if channels and the RTL.

class modexp_checker;
  typedef struct {
    bit [mexp_pkg::DATA_W-1:0] result;
    bit                        bad_modulus;
  } power_t;

  bit [mexp_pkg::DATA_W-1:0] exponent;
  bit [mexp_pkg::DATA_W-1:0] modulus;
  power_t                    pending_powers[$];
  int                        errors;

  function void set_reg(bit [mexp_pkg::CFG_IDX_W-1:0] idx, bit [mexp_pkg::DATA_W-1:0] data);
    case (idx)
      mexp_pkg::REG_EXPONENT: exponent = data;
      mexp_pkg::REG_MODULUS:  modulus  = data;
      default: ;
    endcase
  endfunction

  function bit [63:0] mulmod(bit [63:0] a, bit [63:0] b, bit [63:0] n);
    bit [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod % {64'd0, n};
    return prod[63:0];
  endfunction

  function power_t modpow(bit [mexp_pkg::DATA_W-1:0] msg);
    bit [63:0] mask;
    bit [63:0] n;
    bit [63:0] e;
    bit [63:0] base;
    bit [63:0] acc;
    power_t    p;
    mask = {64{1'b1}} >> (64 - mexp_pkg::WIDTH);
    n    = modulus & mask;
    e    = exponent & mask;
    base = msg & mask;
    acc  = 64'd1;
    if (n < 2) begin
      p.result      = '0;
      p.bad_modulus = 1'b1;
      return p;
    end
    while (e != 0) begin
      if (e[0]) begin
        acc = mulmod(acc, base, n);
      end
      e    = e >> 1;
      base = mulmod(base, base, n);
    end
    p.result      = acc & mask;
    p.bad_modulus = 1'b0;
    return p;
  endfunction

  function void note_message(bit [mexp_pkg::DATA_W-1:0] msg);
    pending_powers.push_back(modpow(msg));
  endfunction

  function void check_result(bit [mexp_pkg::DATA_W-1:0] res, bit bad);
    power_t want;
    if (pending_powers.size() == 0) begin
      $display("%0t: unexpected result transfer, expected none, got result %h bad_modulus %b",
               $time, res, bad);
      errors++;
      return;
    end
    want = pending_powers.pop_front();
    if (res !== want.result) begin
      $display("%0t: result mismatch, expected %h, got %h", $time, want.result, res);
      errors++;
    end
    if (bad !== want.bad_modulus) begin
      $display("%0t: bad_modulus mismatch, expected %b, got %b", $time, want.bad_modulus, bad);
      errors++;
    end
  endfunction
endclass

module modular_exponentiation_unit_tb;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int ITEMS          = 1200;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 100;

  logic clk;
  logic rst_n;

  mexp_in_if  msg_if();
  mexp_out_if res_if();
  mexp_cfg_if key_if();

  modexp_checker sb = new;

  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  int items_sent;

  modular_exponentiation_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (msg_if),
    .out_ch (res_if),
    .cfg_ch (key_if)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 78; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 78; end
      default:   begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  // all drivers enter and leave at a falling edge
  task automatic send_message(bit [mexp_pkg::DATA_W-1:0] msg);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_if.valid = 1'b0;
      @(negedge clk);
    end
    msg_if.valid   = 1'b1;
    msg_if.message = msg;
    do @(posedge clk); while (msg_if.ready !== 1'b1);
    sb.note_message(msg);
    items_sent++;
    @(negedge clk);
    msg_if.valid = 1'b0;
  endtask

  task automatic write_reg(bit [mexp_pkg::CFG_IDX_W-1:0] idx, bit [mexp_pkg::DATA_W-1:0] data);
    key_if.valid     = 1'b1;
    key_if.reg_index = idx;
    key_if.data      = data;
    do @(posedge clk); while (key_if.ready !== 1'b1);
    sb.set_reg(idx, data);
    @(negedge clk);
    key_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_powers.size() != 0) @(negedge clk);
  endtask

  task automatic load_key(bit [mexp_pkg::DATA_W-1:0] e, bit [mexp_pkg::DATA_W-1:0] n);
    wait_drained();
    write_reg(mexp_pkg::REG_EXPONENT, e);
    write_reg(mexp_pkg::REG_MODULUS, n);
  endtask

  function automatic bit [63:0] rand_word(int bits);
    bit [63:0] w;
    w = {$urandom, $urandom};
    if (bits < 64) begin
      w = w & ((64'd1 << bits) - 1);
    end
    return w;
  endfunction

  // receiver side
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      sb.check_result(res_if.result, res_if.bad_modulus);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready) ||
        (key_if.valid && key_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit [63:0] e;
    bit [63:0] n;
    bit [63:0] msg;
    int        phase;
    int        count;
    int        roll;
    int        bits;
    bit        big_exp;

    msg_if.valid     = 1'b0;
    msg_if.message   = '0;
    key_if.valid     = 1'b0;
    key_if.reg_index = '0;
    key_if.data      = '0;
    quiet_cycles     = 0;
    items_sent       = 0;
    set_idling(IDLE_NONE);
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset key: modulus 0 flags every item
    send_message('0);
    send_message('1);

    // zero exponent gives 1
    load_key(64'd0, '1);
    send_message(64'd12345);
    send_message('1);

    // modulus of one
    load_key(64'd5, 64'd1);
    send_message(64'd7);

    // smallest valid modulus, full exponent
    load_key('1, 64'd2);
    send_message('1);
    send_message(64'd2);

    // largest modulus and exponent; message equal to modulus
    load_key('1, '1);
    send_message('1);
    send_message('0);
    send_message(64'd1);
    send_message(64'hFFFF_FFFF_FFFF_FFFE);

    // largest 64-bit prime, common public exponent, message above modulus
    load_key(64'd65537, 64'hFFFF_FFFF_FFFF_FFC5);
    send_message(64'h0123_4567_89AB_CDEF);
    send_message(64'hFFFF_FFFF_FFFF_FFCA);

    // textbook key pair, encrypt then decrypt
    load_key(64'd17, 64'd3233);
    send_message(64'd65);
    load_key(64'd2753, 64'd3233);
    send_message(64'd2790);

    // writes to unused indexes leave the key alone
    wait_drained();
    write_reg(mexp_pkg::CFG_IDX_W'(2), '1);
    write_reg('1, '0);
    send_message(64'd42);

    for (phase = 0; items_sent < ITEMS; phase++) begin
      set_idling(idle_mode_e'(phase % 4));
      big_exp = 1'b0;
      roll = $urandom_range(99);
      if (roll < 5) begin
        e = '0;
      end else if (roll < 12) begin
        e = rand_word(64) | (64'd1 << 63);
        big_exp = 1'b1;
      end else begin
        bits = $urandom_range(6, 1);
        e = rand_word(bits) | (64'd1 << (bits - 1));
      end
      roll = $urandom_range(99);
      if (roll < 8) begin
        n = 64'($urandom_range(1, 0));
      end else if (roll < 12) begin
        n = 64'd2;
      end else if (roll < 18) begin
        n = '1;
      end else begin
        bits = $urandom_range(64, 2);
        n = rand_word(bits) | (64'd1 << (bits - 1));
      end
      wait_drained();
      if ($urandom_range(1)) begin
        write_reg(mexp_pkg::REG_MODULUS, n);
        write_reg(mexp_pkg::REG_EXPONENT, e);
      end else begin
        write_reg(mexp_pkg::REG_EXPONENT, e);
        write_reg(mexp_pkg::REG_MODULUS, n);
      end
      if ($urandom_range(9) == 0) begin
        write_reg(mexp_pkg::CFG_IDX_W'($urandom_range(255, 2)), rand_word(64));
      end
      count = big_exp ? 3 : $urandom_range(40, 20);
      repeat (count) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          msg = '0;
        end else if (roll < 14) begin
          msg = '1;
        end else if (roll < 30) begin
          msg = n + 64'($urandom_range(3));
        end else if (roll < 50) begin
          msg = rand_word($urandom_range(64, 1));
        end else begin
          msg = rand_word(64);
        end
        send_message(msg);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending_powers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
